FILE: hdl/blars_pkg.sv
// Shared types, constants and table builder for the band level smoother.
package blars_pkg;

	localparam int RAW_W   = 20;
	localparam int GAIN_W  = 16;
	localparam int COUNT_W = 6;
	localparam int LEVEL_W = 17;
	localparam int DT_W    = 7;
	localparam int DT_MAX  = 100;

	localparam logic [GAIN_W-1:0]  GAIN_RESET  = 16'd256;
	localparam logic [COUNT_W-1:0] COUNT_RESET = 6'd32;

	// Configuration register indexes.
	typedef enum logic [0:0] {
		CFG_LEVEL_GAIN = 1'b0,
		CFG_BAND_COUNT = 1'b1
	} cfg_reg_t;

	// Time-constant rows of the alpha table.
	typedef enum logic [2:0] {
		ROW_RISE_FAST = 3'd0,
		ROW_RISE_SLOW = 3'd1,
		ROW_FALL_FAST = 3'd2,
		ROW_FALL_SLOW = 3'd3,
		ROW_IDLE      = 3'd4
	} alpha_row_sel_t;

	localparam int ROWS = 5;

	// Per-item flags carried from the front end to the back end.
	typedef struct packed {
		logic            has_value;
		logic            last;
		logic [DT_W-1:0] dt;
	} item_flags_t;

	typedef logic [0:DT_MAX][31:0] alpha_row_t;

	// round(2^30 * exp(-1/tau)) for tau 18, 28, 32, 58 and 170 ms.
	localparam logic [31:0] DECAY_RATIO [ROWS] = '{
		32'd1015716246,
		32'd1036070606,
		32'd1040706261,
		32'd1055387714,
		32'd1067444236
	};

	// Build one row of alpha = 1 - r^dt in Q.frac, rounded to nearest.
	function automatic alpha_row_t alpha_row(input int row, input int frac);
		logic [63:0] p;
		logic [63:0] a;
		alpha_row_t  r;
		p = 64'd1 << 30;
		r = '0;
		for (int dt = 0; dt <= DT_MAX; dt++) begin
			if (dt > 0)
				p = (p * {32'd0, DECAY_RATIO[row]} + (64'd1 << 29)) >> 30;
			a = (((64'd1 << 30) - p) + ((64'd1 << (30 - frac)) >> 1)) >> (30 - frac);
			r[dt] = a[31:0];
		end
		return r;
	endfunction

endpackage

FILE: hdl/blars_if.sv
// Stream interfaces for raw band levels and smoothed results.
interface blars_in_if;
	logic        valid;
	logic        ready;
	logic [19:0] raw_level;
	logic        has_value;
	logic [7:0]  elapsed_ms;

	modport source (output valid, output raw_level, output has_value, output elapsed_ms,
		input ready);
	modport sink (input valid, input raw_level, input has_value, input elapsed_ms,
		output ready);
endinterface

interface blars_out_if;
	logic        valid;
	logic        ready;
	logic [16:0] band_level;
	logic        band_changed;
	logic        frame_last;
	logic        all_settled;

	modport source (output valid, output band_level, output band_changed,
		output frame_last, output all_settled, input ready);
	modport sink (input valid, input band_level, input band_changed,
		input frame_last, input all_settled, output ready);
endinterface

FILE: hdl/blars_front.sv
// Front end: accepts raw levels, tracks band position, forms target and flags.
module blars_front #(
	parameter int MAX_BANDS       = 32,
	parameter int LEVEL_FRAC_BITS = 16,
	parameter int CW              = $clog2(MAX_BANDS + 1),
	parameter int QW              = 32
) (
	input  logic           clk,
	input  logic           arst_n,
	blars_in_if.sink       levels,
	input  logic [blars_pkg::GAIN_W-1:0] level_gain,
	input  logic [CW-1:0]  eff_count,
	input  logic           q_full,
	output logic           push,
	output logic [QW-1:0]  push_data
);
	import blars_pkg::*;

	localparam int PW   = $clog2(MAX_BANDS);
	localparam int VW   = (LEVEL_FRAC_BITS + 1 > LEVEL_W) ? LEVEL_FRAC_BITS + 1 : LEVEL_W;
	localparam int ONE  = 1 << LEVEL_FRAC_BITS;
	localparam int IDLE = (ONE + 50) / 100;
	localparam int PRW  = RAW_W + GAIN_W;

	logic [PW-1:0]   pos_q;
	logic [CW-1:0]   pos_inc;
	logic            last;
	logic [PRW-1:0]  scaled;
	logic [VW-1:0]   target;
	logic [DT_W-1:0] dt;
	item_flags_t     flags;

	assign levels.ready = !q_full;
	assign push         = levels.valid && !q_full;

	assign pos_inc = CW'(pos_q) + CW'(1);
	assign last    = pos_inc >= eff_count;

	always_comb begin
		scaled = (PRW'(levels.raw_level) * PRW'(level_gain)) >> (24 - LEVEL_FRAC_BITS);
		if (!levels.has_value)
			target = VW'(IDLE);
		else if (scaled > PRW'(ONE))
			target = VW'(ONE);
		else if (scaled < PRW'(IDLE))
			target = VW'(IDLE);
		else
			target = scaled[VW-1:0];

		if (levels.elapsed_ms == 8'd0)
			dt = DT_W'(1);
		else if (levels.elapsed_ms > 8'(DT_MAX))
			dt = DT_W'(DT_MAX);
		else
			dt = levels.elapsed_ms[DT_W-1:0];

		flags.has_value = levels.has_value;
		flags.last      = last;
		flags.dt        = dt;
	end

	assign push_data = {target, pos_q, flags};

	// Advance band position per accepted transaction, wrap on the last band.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (push) begin
			pos_q <= last ? '0 : pos_inc[PW-1:0];
		end
	end

endmodule

FILE: hdl/blars_queue.sv
// Short FIFO that decouples the front end from the back end.
module blars_queue #(
	parameter int W = 32
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] push_data,
	output logic         full,
	input  logic         pop,
	output logic [W-1:0] head,
	output logic         empty
);
	localparam int DEPTH = 4;
	localparam int AW    = $clog2(DEPTH);

	logic [W-1:0]  entries [DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [AW:0]   count_q;

	assign full  = count_q == (AW + 1)'(DEPTH);
	assign empty = count_q == '0;
	assign head  = entries[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			entries[wr_ptr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + AW'(1);
			if (pop)
				rd_ptr_q <= rd_ptr_q + AW'(1);
			if (push && !pop)
				count_q <= count_q + (AW + 1)'(1);
			else if (pop && !push)
				count_q <= count_q - (AW + 1)'(1);
		end
	end

endmodule

FILE: hdl/blars_back.sv
// Back end: level store read-modify-write, attack/release step, frame peak.
module blars_back #(
	parameter int MAX_BANDS       = 32,
	parameter int LEVEL_FRAC_BITS = 16,
	parameter int CW              = $clog2(MAX_BANDS + 1),
	parameter int QW              = 32
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic [QW-1:0] head,
	input  logic          q_empty,
	output logic          pop,
	input  logic          clear,
	input  logic [CW-1:0] clear_count,
	blars_out_if.source   results
);
	import blars_pkg::*;

	localparam int F      = LEVEL_FRAC_BITS;
	localparam int PW     = $clog2(MAX_BANDS);
	localparam int VW     = (F + 1 > LEVEL_W) ? F + 1 : LEVEL_W;
	localparam int AW     = F + 1;
	localparam int PRW    = VW + AW + 1;
	localparam int FW     = $bits(item_flags_t);
	localparam int ONE    = 1 << F;
	localparam int IDLE   = (ONE + 50) / 100;
	localparam int THRESH = (ONE + 500) / 1000;
	localparam int JUMP   = ONE / 4;
	localparam int SETTLE = (12 * ONE + 500) / 1000;
	localparam int HALF   = ONE / 2;

	localparam alpha_row_t ALPHA_TAB [ROWS] = '{
		alpha_row(0, F), alpha_row(1, F), alpha_row(2, F), alpha_row(3, F), alpha_row(4, F)
	};

	// Queue head fields.
	item_flags_t   hd_flags;
	logic [PW-1:0] hd_pos;
	logic [VW-1:0] hd_target;

	assign hd_flags  = head[FW-1:0];
	assign hd_pos    = head[FW +: PW];
	assign hd_target = head[FW + PW +: VW];

	// Level store with per-entry valid bits; an invalid entry reads as idle.
	logic [LEVEL_W-1:0] mem [MAX_BANDS];
	logic               vb_q [MAX_BANDS];

	logic en;
	logic hazard;
	logic commit;

	// Stage 1: stored level arrives.
	logic               valid_s1;
	logic [VW-1:0]      target_s1;
	logic [PW-1:0]      pos_s1;
	item_flags_t        flags_s1;
	logic [LEVEL_W-1:0] rd_s1;
	logic               rdv_s1;

	// Stage 2: difference and alpha registered.
	logic          valid_s2;
	logic [VW-1:0] d_s2;
	logic [VW-1:0] cur_s2;
	logic [VW-1:0] target_s2;
	logic [AW-1:0] alpha_s2;
	logic          up_s2;
	logic          move_s2;
	logic          last_s2;
	logic [PW-1:0] pos_s2;

	// Stage 3: step product registered.
	logic           valid_s3;
	logic [PRW-1:0] prod_s3;
	logic [VW-1:0]  d_s3;
	logic [VW-1:0]  cur_s3;
	logic [VW-1:0]  target_s3;
	logic           up_s3;
	logic           move_s3;
	logic           last_s3;
	logic [PW-1:0]  pos_s3;

	logic               out_valid_q;
	logic [LEVEL_W-1:0] level_q;
	logic               changed_q;
	logic               last_q;
	logic               settled_q;
	logic [LEVEL_W-1:0] peak_q;

	// Stage 1 logic.
	logic [VW-1:0]  cur;
	logic           up;
	logic [VW-1:0]  d;
	alpha_row_sel_t row;
	logic [AW-1:0]  alpha_at [ROWS];
	logic [AW-1:0]  alpha;

	// Stage 2 and 3 logic.
	logic [PRW-1:0]     prod;
	logic [VW+1:0]      mv_full;
	logic [VW-1:0]      mv;
	logic [VW-1:0]      nxt;
	logic [LEVEL_W-1:0] nxt_lvl;
	logic [LEVEL_W-1:0] peak_new;
	logic               settled;

	assign en     = !out_valid_q || results.ready;
	assign hazard = (valid_s1 && pos_s1 == hd_pos) || (valid_s2 && pos_s2 == hd_pos)
		|| (valid_s3 && pos_s3 == hd_pos);
	assign pop    = en && !q_empty && !hazard;
	assign commit = en && valid_s3;

	always_comb begin
		cur = rdv_s1 ? VW'(rd_s1) : VW'(IDLE);
		up  = target_s1 > cur;
		d   = up ? target_s1 - cur : cur - target_s1;

		if (!flags_s1.has_value)
			row = ROW_IDLE;
		else if (up)
			row = (d > VW'(JUMP)) ? ROW_RISE_FAST : ROW_RISE_SLOW;
		else
			row = (d > VW'(JUMP)) ? ROW_FALL_FAST : ROW_FALL_SLOW;

		for (int r = 0; r < ROWS; r++)
			alpha_at[r] = ALPHA_TAB[r][flags_s1.dt][AW-1:0];

		unique case (row)
			ROW_RISE_FAST: alpha = alpha_at[0];
			ROW_RISE_SLOW: alpha = alpha_at[1];
			ROW_FALL_FAST: alpha = alpha_at[2];
			ROW_FALL_SLOW: alpha = alpha_at[3];
			ROW_IDLE:      alpha = alpha_at[4];
			default:       alpha = '0;
		endcase
	end

	assign prod = PRW'(d_s2) * PRW'(alpha_s2) + PRW'(HALF);

	always_comb begin
		mv_full = prod_s3[F +: VW + 2];
		mv      = (mv_full > (VW + 2)'(d_s3)) ? d_s3 : mv_full[VW-1:0];
		if (move_s3)
			nxt = up_s3 ? cur_s3 + mv : cur_s3 - mv;
		else
			nxt = target_s3;
		nxt_lvl  = nxt[LEVEL_W-1:0];
		peak_new = (nxt_lvl > peak_q) ? nxt_lvl : peak_q;
		settled  = last_s3 && (VW'(peak_new) <= VW'(SETTLE));
	end

	// Read at issue, write at commit.
	always_ff @(posedge clk) begin
		if (commit)
			mem[pos_s3] <= nxt_lvl;
		if (pop)
			rd_s1 <= mem[hd_pos];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_BANDS; i++)
				vb_q[i] <= 1'b0;
			rdv_s1 <= 1'b0;
		end else begin
			if (pop)
				rdv_s1 <= vb_q[hd_pos];
			if (commit)
				vb_q[pos_s3] <= 1'b1;
			// Drop bands at or above the new count back to idle.
			if (clear) begin
				for (int i = 0; i < MAX_BANDS; i++)
					if (CW'(i) >= clear_count)
						vb_q[i] <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			valid_s3    <= 1'b0;
			out_valid_q <= 1'b0;
			peak_q      <= '0;
		end else if (en) begin
			valid_s1    <= pop;
			valid_s2    <= valid_s1;
			valid_s3    <= valid_s2;
			out_valid_q <= valid_s3;
			if (valid_s3)
				peak_q <= last_s3 ? '0 : peak_new;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (pop) begin
				target_s1 <= hd_target;
				pos_s1    <= hd_pos;
				flags_s1  <= hd_flags;
			end
			d_s2      <= d;
			cur_s2    <= cur;
			target_s2 <= target_s1;
			alpha_s2  <= alpha;
			up_s2     <= up;
			move_s2   <= d > VW'(THRESH);
			last_s2   <= flags_s1.last;
			pos_s2    <= pos_s1;

			prod_s3   <= prod;
			d_s3      <= d_s2;
			cur_s3    <= cur_s2;
			target_s3 <= target_s2;
			up_s3     <= up_s2;
			move_s3   <= move_s2;
			last_s3   <= last_s2;
			pos_s3    <= pos_s2;

			level_q   <= nxt_lvl;
			changed_q <= move_s3;
			last_q    <= last_s3;
			settled_q <= settled;
		end
	end

	assign results.valid        = out_valid_q;
	assign results.band_level   = level_q;
	assign results.band_changed = changed_q;
	assign results.frame_last   = last_q;
	assign results.all_settled  = settled_q;

endmodule

FILE: hdl/band_level_attack_release_smoother_top.sv
// Top level of the band level attack/release smoother.
// One band level is taken per cycle while the queue has room, and one smoothed result comes
// out per band, in order. The level store is read, stepped and written back over a three-stage
// path (store read, alpha lookup, step multiply), and a band cannot issue while its own
// previous update is still on that path, so it waits until that update is written back. A
// four-entry queue sits between the input side and the store pipeline, and an output register
// holds a result that is not yet taken, so input keeps flowing while the output stalls until
// the queue is full. Stored levels come out of reset at the idle value through per-band valid
// bits; writing band_count returns bands at or above the new count to idle at once. Write
// configuration only while no transaction is in flight.
module band_level_attack_release_smoother_top #(
	parameter int MAX_BANDS       = 32,
	parameter int LEVEL_FRAC_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	blars_in_if.sink                      levels,
	blars_out_if.source                   results,
	input  logic                          cfg_we,
	input  blars_pkg::cfg_reg_t           cfg_index,
	input  logic [blars_pkg::GAIN_W-1:0]  cfg_data
);
	import blars_pkg::*;

	localparam int CW   = $clog2(MAX_BANDS + 1);
	localparam int PW   = $clog2(MAX_BANDS);
	localparam int VW   = (LEVEL_FRAC_BITS + 1 > LEVEL_W) ? LEVEL_FRAC_BITS + 1 : LEVEL_W;
	localparam int QW   = VW + PW + $bits(item_flags_t);
	localparam int ONE  = 1 << LEVEL_FRAC_BITS;
	localparam int IDLE = (ONE + 50) / 100;

	logic [GAIN_W-1:0]  level_gain_q;
	logic [COUNT_W-1:0] band_count_q;
	logic [CW-1:0]      eff_count;
	logic [CW-1:0]      new_count;
	logic               clear;

	logic          push;
	logic [QW-1:0] push_data;
	logic          q_full;
	logic          pop;
	logic [QW-1:0] head;
	logic          q_empty;

	function automatic logic [CW-1:0] clamp_count(input logic [COUNT_W-1:0] c);
		if (int'(c) < 2)
			return CW'(2);
		else if (int'(c) > MAX_BANDS)
			return CW'(MAX_BANDS);
		else
			return CW'(c);
	endfunction

	assign eff_count = clamp_count(band_count_q);
	assign new_count = clamp_count(cfg_data[COUNT_W-1:0]);
	assign clear     = cfg_we && (cfg_index == CFG_BAND_COUNT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_gain_q <= GAIN_RESET;
			band_count_q <= COUNT_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_LEVEL_GAIN: level_gain_q <= cfg_data;
				CFG_BAND_COUNT: band_count_q <= cfg_data[COUNT_W-1:0];
			endcase
		end
	end

	blars_front #(
		.MAX_BANDS       (MAX_BANDS),
		.LEVEL_FRAC_BITS (LEVEL_FRAC_BITS),
		.CW              (CW),
		.QW              (QW)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.levels     (levels),
		.level_gain (level_gain_q),
		.eff_count  (eff_count),
		.q_full     (q_full),
		.push       (push),
		.push_data  (push_data)
	);

	blars_queue #(
		.W (QW)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (q_full),
		.pop       (pop),
		.head      (head),
		.empty     (q_empty)
	);

	blars_back #(
		.MAX_BANDS       (MAX_BANDS),
		.LEVEL_FRAC_BITS (LEVEL_FRAC_BITS),
		.CW              (CW),
		.QW              (QW)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head        (head),
		.q_empty     (q_empty),
		.pop         (pop),
		.clear       (clear),
		.clear_count (new_count),
		.results     (results)
	);

	// The settled flag is only ever raised on the last band of a frame.
	a_settled_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		results.valid && results.all_settled |-> results.frame_last)
		else $error("all_settled raised off the last band");

	// A smoothed level always lies between idle and full scale.
	a_level_range: assert property (@(posedge clk) disable iff (!arst_n)
		results.valid |-> (LEVEL_FRAC_BITS > 16) ||
			((int'(results.band_level) >= IDLE) && (int'(results.band_level) <= ONE)))
		else $error("band level out of range");

	// The queue never pops when it is empty.
	a_no_empty_pop: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !q_empty)
		else $error("pop from empty queue");

endmodule
